[sv/bf3_pkg.sv]
`timescale 1ns / 1ps

package bf3_pkg;

    localparam int PIX_W      = 8;
    localparam int LEN_CFG_W  = 10;
    localparam int CNT_CFG_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_LINE_W = 10;
    localparam int OUT_COL_W  = 9;

    localparam int LINE_LENGTH_RESET = 384;
    localparam int LINE_COUNT_RESET  = 288;
    localparam int MIN_SIZE          = 3;

    // window geometry: three columns, the newest comes straight from the line stores and the incoming pixel
    localparam int WIN_COLS     = 3;
    localparam int STORED_COLS  = WIN_COLS - 1;
    localparam int COL_SUM_W    = 10;
    localparam int SUM_W        = 12;

    // divide by nine as a multiply by ceil(2^16 / 9), exact for sums up to 9 * 255
    localparam int RECIP_W      = 13;
    localparam int RECIP_SHIFT  = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
    localparam int PROD_W       = SUM_W + RECIP_W;

    typedef enum logic
    {
        REG_LINE_LENGTH = 1'b0,
        REG_LINE_COUNT  = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_beat_t;

    typedef struct packed
    {
        logic [PIX_W-1:0]      smoothed;
        logic [OUT_LINE_W-1:0] out_line;
        logic [OUT_COL_W-1:0]  out_column;
        logic                  frame_done;
    } result_beat_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] lower;
    } column_t;

endpackage

[sv/bf3_line_store.sv]
`timescale 1ns / 1ps

module bf3_line_store
    import bf3_pkg::*;
#(
    parameter int DEPTH = 512
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [PIX_W-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [PIX_W-1:0]         rd_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bf3_column_cell.sv]
`timescale 1ns / 1ps

module bf3_column_cell
    import bf3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  column_t              col_in,
    output column_t              col_out,
    output logic [COL_SUM_W-1:0] col_sum
);

    column_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;
    assign col_sum = COL_SUM_W'(col_reg.upper) + COL_SUM_W'(col_reg.middle)
                   + COL_SUM_W'(col_reg.lower);

endmodule

[sv/box_filter_3x3_stream.sv]
`timescale 1ns / 1ps

// 3x3 box filter on an 8-bit grayscale pixel stream in raster order.
// pixel channel: pixel_valid / pixel_stall / pixel_data, one pixel per beat;
// frame_start on a beat restarts the line and column count at that pixel.
// result channel: result_valid / result_stall / result_data, one beat per
// interior pixel (line and column both at least 1 and below the last one),
// carrying the truncated mean of its neighborhood, its line and column and
// a frame_done flag on the last interior pixel. border pixels give no beat.
// cfg_we / cfg_index / cfg_data write line_length (0) and line_count (1);
// write them only while the block is idle.
// throughput: one pixel per cycle while pixel_stall is low. a pixel taken
// passes stage 1 (store read with the pixel), stage 2 (window sum) and the
// multiply by 1/9 into the output register before its result beat is valid.
// a stalled receiver with a result beat waiting freezes the whole pipeline
// and raises pixel_stall.
// after reset the two line stores are cleared, one address per cycle, and
// pixel_stall stays high until address MAX_LINE_PIXELS - 1 is cleared.
module box_filter_3x3_stream
    import bf3_pkg::*;
#(
    parameter int MAX_LINE_PIXELS = 512,
    parameter int MAX_LINES       = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_beat_t           pixel_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_beat_t          result_data,
    input  logic                  cfg_we,
    input  reg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
    localparam int LEN_W  = $clog2(MAX_LINE_PIXELS + 1);
    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int LEN_RESET_CLAMPED =
        (LINE_LENGTH_RESET > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : LINE_LENGTH_RESET;
    localparam int CNT_RESET_CLAMPED =
        (LINE_COUNT_RESET > MAX_LINES) ? MAX_LINES : LINE_COUNT_RESET;

    // effective sizes, clamped when written
    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      len_req;
    logic [31:0]      cnt_req;
    logic [31:0]      len_clamped;
    logic [31:0]      cnt_clamped;

    // store clearing after reset
    logic             clr_active_reg;
    logic [COL_W-1:0] clr_addr_reg;

    // position counters
    logic [COL_W-1:0]  col_reg;
    logic [LINE_W-1:0] line_reg;
    logic [COL_W-1:0]  cur_col;
    logic [LINE_W-1:0] cur_line;
    logic [LEN_W-1:0]  col_p1;
    logic [CNT_W-1:0]  line_p1;
    logic              col_wrap;
    logic [COL_W-1:0]  col_next;
    logic [LINE_W-1:0] line_next;
    logic              cur_emit;
    logic              cur_done;
    logic [31:0]       cur_line_m1;
    logic [31:0]       cur_col_m1;

    logic advance;
    logic accept;

    // stage 1: store read data present
    logic                  s1_valid_reg;
    logic [PIX_W-1:0]      s1_px_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic                  s1_emit_reg;
    logic [OUT_LINE_W-1:0] s1_line_out_reg;
    logic [OUT_COL_W-1:0]  s1_col_out_reg;
    logic                  s1_done_reg;
    logic                  fwd_hit_reg;
    logic [PIX_W-1:0]      fwd_upper_reg;
    logic [PIX_W-1:0]      fwd_middle_reg;

    logic [PIX_W-1:0]     upper_rd;
    logic [PIX_W-1:0]     middle_rd;
    logic [PIX_W-1:0]     top_px;
    logic [PIX_W-1:0]     mid_px;
    logic                 st_we;
    logic [COL_W-1:0]     st_wr_addr;
    logic [PIX_W-1:0]     upper_wr_data;
    logic [PIX_W-1:0]     middle_wr_data;
    logic                 win_shift;
    column_t              cur_column;
    column_t              cell_link [STORED_COLS+1];
    logic [COL_SUM_W-1:0] cell_sum [STORED_COLS];
    logic [COL_SUM_W-1:0] cur_col_sum;
    logic [SUM_W-1:0]     win_sum;

    // stage 2: window sum
    logic                  s2_valid_reg;
    logic [SUM_W-1:0]      s2_sum_reg;
    logic [OUT_LINE_W-1:0] s2_line_out_reg;
    logic [OUT_COL_W-1:0]  s2_col_out_reg;
    logic                  s2_done_reg;
    logic [PROD_W-1:0]     s2_prod;

    logic         result_valid_reg;
    result_beat_t result_data_reg;

    // configuration
    always_comb
    begin
        len_req = 32'(cfg_data[LEN_CFG_W-1:0]);
        cnt_req = 32'(cfg_data[CNT_CFG_W-1:0]);
        if (len_req < 32'(MIN_SIZE))
        begin
            len_clamped = 32'(MIN_SIZE);
        end
        else if (len_req > 32'(MAX_LINE_PIXELS))
        begin
            len_clamped = 32'(MAX_LINE_PIXELS);
        end
        else
        begin
            len_clamped = len_req;
        end
        if (cnt_req < 32'(MIN_SIZE))
        begin
            cnt_clamped = 32'(MIN_SIZE);
        end
        else if (cnt_req > 32'(MAX_LINES))
        begin
            cnt_clamped = 32'(MAX_LINES);
        end
        else
        begin
            cnt_clamped = cnt_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(LEN_RESET_CLAMPED);
            cnt_reg <= CNT_W'(CNT_RESET_CLAMPED);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_LENGTH: len_reg <= len_clamped[LEN_W-1:0];
                REG_LINE_COUNT:  cnt_reg <= cnt_clamped[CNT_W-1:0];
                default:         len_reg <= len_reg;
            endcase
        end
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(MAX_LINE_PIXELS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // handshake
    assign advance     = !result_valid_reg || !result_stall;
    assign pixel_stall = clr_active_reg || !advance;
    assign accept      = pixel_valid && !pixel_stall;

    // position of the incoming pixel
    always_comb
    begin
        cur_col     = pixel_data.frame_start ? '0 : col_reg;
        cur_line    = pixel_data.frame_start ? '0 : line_reg;
        col_p1      = LEN_W'(cur_col) + LEN_W'(1);
        line_p1     = CNT_W'(cur_line) + CNT_W'(1);
        col_wrap    = col_p1 >= len_reg;
        col_next    = col_wrap ? '0 : col_p1[COL_W-1:0];
        line_next   = cur_line;
        if (col_wrap)
        begin
            line_next = (line_p1 >= cnt_reg) ? '0 : line_p1[LINE_W-1:0];
        end
        cur_emit    = (cur_line >= LINE_W'(2)) && (cur_col >= COL_W'(2))
                   && (CNT_W'(cur_line) < cnt_reg) && (LEN_W'(cur_col) < len_reg);
        cur_done    = (CNT_W'(cur_line) == cnt_reg - CNT_W'(1))
                   && (LEN_W'(cur_col) == len_reg - LEN_W'(1));
        cur_line_m1 = 32'(cur_line) - 32'd1;
        cur_col_m1  = 32'(cur_col) - 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                fwd_hit_reg <= s1_valid_reg && (s1_col_reg == cur_col);
            end
        end
    end

    // stage 1 payload; a hit means the previous pixel writes this address on the same edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= pixel_data.pixel;
            s1_col_reg      <= cur_col;
            s1_emit_reg     <= cur_emit;
            s1_line_out_reg <= cur_line_m1[OUT_LINE_W-1:0];
            s1_col_out_reg  <= cur_col_m1[OUT_COL_W-1:0];
            s1_done_reg     <= cur_done;
            fwd_upper_reg   <= mid_px;
            fwd_middle_reg  <= s1_px_reg;
        end
    end

    assign top_px = fwd_hit_reg ? fwd_upper_reg  : upper_rd;
    assign mid_px = fwd_hit_reg ? fwd_middle_reg : middle_rd;

    // line stores
    assign st_we          = clr_active_reg || (s1_valid_reg && advance);
    assign st_wr_addr     = clr_active_reg ? clr_addr_reg : s1_col_reg;
    assign upper_wr_data  = clr_active_reg ? '0 : mid_px;
    assign middle_wr_data = clr_active_reg ? '0 : s1_px_reg;

    bf3_line_store #(
        .DEPTH (MAX_LINE_PIXELS)
    ) u_store_upper (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_wr_addr),
        .wr_data (upper_wr_data),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (upper_rd)
    );

    bf3_line_store #(
        .DEPTH (MAX_LINE_PIXELS)
    ) u_store_middle (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_wr_addr),
        .wr_data (middle_wr_data),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (middle_rd)
    );

    // window: newest column enters the chain, each cell hands its column on
    assign win_shift         = s1_valid_reg && advance;
    assign cur_column.upper  = top_px;
    assign cur_column.middle = mid_px;
    assign cur_column.lower  = s1_px_reg;
    assign cell_link[0]      = cur_column;

    for (genvar i = 0; i < STORED_COLS; i++)
    begin : g_cell
        bf3_column_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (win_shift),
            .col_in  (cell_link[i]),
            .col_out (cell_link[i+1]),
            .col_sum (cell_sum[i])
        );
    end

    always_comb
    begin
        cur_col_sum = COL_SUM_W'(top_px) + COL_SUM_W'(mid_px) + COL_SUM_W'(s1_px_reg);
        win_sum     = SUM_W'(cur_col_sum);
        for (int k = 0; k < STORED_COLS; k++)
        begin
            win_sum = win_sum + SUM_W'(cell_sum[k]);
        end
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sum_reg      <= win_sum;
            s2_line_out_reg <= s1_line_out_reg;
            s2_col_out_reg  <= s1_col_out_reg;
            s2_done_reg     <= s1_done_reg;
        end
    end

    assign s2_prod = PROD_W'(s2_sum_reg) * PROD_W'(RECIP_NINE);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_data_reg.smoothed   <= s2_prod[RECIP_SHIFT +: PIX_W];
            result_data_reg.out_line   <= s2_line_out_reg;
            result_data_reg.out_column <= s2_col_out_reg;
            result_data_reg.frame_done <= s2_done_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !accept)
        else $error("pixel taken during store clearing");

    a_forward_needs_writer : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_hit_reg) |-> $past(s1_valid_reg))
        else $error("store forward without a pending write");

    a_stage2_from_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_valid_reg) |=> !s2_valid_reg)
        else $error("window sum stage filled from an empty stage");
`endif

endmodule
